// ===== sv/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared constants for the rotation-matrix-to-quaternion block.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // default number format: signed Q2.14
  localparam int unsigned DATA_WIDTH = 16;
  localparam int unsigned FRAC_BITS  = 14;

  // quaternion lanes in the divider chain
  localparam int unsigned LANES  = 4;
  localparam int unsigned LANE_W = 0;
  localparam int unsigned LANE_X = 1;
  localparam int unsigned LANE_Y = 2;
  localparam int unsigned LANE_Z = 3;

endpackage

// ===== sv/rmq_if.sv =====
// ----------------------------------------------------------------------------
// rmq_in_if / rmq_out_if
// Valid/ready channels carrying a matrix request and a quaternion result.
// ----------------------------------------------------------------------------
interface rmq_in_if #(
  parameter int unsigned DATA_WIDTH = rmq_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] row0_col0;
  logic signed [DATA_WIDTH-1:0] row0_col1;
  logic signed [DATA_WIDTH-1:0] row0_col2;
  logic signed [DATA_WIDTH-1:0] row1_col0;
  logic signed [DATA_WIDTH-1:0] row1_col1;
  logic signed [DATA_WIDTH-1:0] row1_col2;
  logic signed [DATA_WIDTH-1:0] row2_col0;
  logic signed [DATA_WIDTH-1:0] row2_col1;
  logic signed [DATA_WIDTH-1:0] row2_col2;

  modport source (
    output valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
           row1_col2, row2_col0, row2_col1, row2_col2,
    input  ready
  );
  modport sink (
    input  valid, row0_col0, row0_col1, row0_col2, row1_col0, row1_col1,
           row1_col2, row2_col0, row2_col1, row2_col2,
    output ready
  );
endinterface

interface rmq_out_if #(
  parameter int unsigned DATA_WIDTH = rmq_pkg::DATA_WIDTH
);
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quat_w;
  logic signed [DATA_WIDTH-1:0] quat_x;
  logic signed [DATA_WIDTH-1:0] quat_y;
  logic signed [DATA_WIDTH-1:0] quat_z;
  logic                         bad_matrix;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, bad_matrix,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, bad_matrix,
    output ready
  );
endinterface

// ===== sv/rmq_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt_cell
// One digit of a pipelined integer square root: takes two radicand bits,
// produces one root bit, and hands the partial state to the next cell.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
  parameter int unsigned SW = 16,
  parameter int unsigned PW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  logic [2*SW-1:0] n_i,
  input  logic [SW+1:0]   rem_i,
  input  logic [SW-1:0]   root_i,
  input  logic [PW-1:0]   pay_i,
  output logic            valid_o,
  output logic [2*SW-1:0] n_o,
  output logic [SW+1:0]   rem_o,
  output logic [SW-1:0]   root_o,
  output logic [PW-1:0]   pay_o
);

  logic            valid_q;
  logic [2*SW-1:0] n_q, n_d;
  logic [SW+1:0]   rem_q, rem_d;
  logic [SW-1:0]   root_q, root_d;
  logic [PW-1:0]   pay_q;
  logic [SW+1:0]   cur;
  logic [SW+1:0]   trial;
  logic            fits;

  // bring down two radicand bits and try the next root bit
  always_comb begin
    cur    = {rem_i[SW-1:0], n_i[2*SW-1 -: 2]};
    trial  = {root_i, 2'b01};
    fits   = (cur >= trial);
    rem_d  = fits ? (cur - trial) : cur;
    root_d = {root_i[SW-2:0], fits};
    n_d    = n_i << 2;
  end

  // hold valid under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // advance the data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= n_d;
      rem_q  <= rem_d;
      root_q <= root_d;
      pay_q  <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign n_o     = n_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign pay_o   = pay_q;

endmodule

// ===== sv/rmq_div_cell.sv =====
// ----------------------------------------------------------------------------
// rmq_div_cell
// One quotient bit of a pipelined restoring divider, four lanes sharing the
// divisor; partial remainders and quotients move to the next cell.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
  parameter int unsigned SW  = 16,
  parameter int unsigned DW  = 16,
  parameter int unsigned RMW = 33,
  parameter int unsigned PW  = 9
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 en_i,
  input  logic                                 valid_i,
  input  logic [SW-1:0]                        s_i,
  input  logic [rmq_pkg::LANES-1:0][RMW-1:0]   rem_i,
  input  logic [rmq_pkg::LANES-1:0][DW-1:0]    q_i,
  input  logic [PW-1:0]                        pay_i,
  output logic                                 valid_o,
  output logic [SW-1:0]                        s_o,
  output logic [rmq_pkg::LANES-1:0][RMW-1:0]   rem_o,
  output logic [rmq_pkg::LANES-1:0][DW-1:0]    q_o,
  output logic [PW-1:0]                        pay_o
);

  logic                               valid_q;
  logic [SW-1:0]                      s_q;
  logic [rmq_pkg::LANES-1:0][RMW-1:0] rem_q, rem_d;
  logic [rmq_pkg::LANES-1:0][DW-1:0]  q_q, q_d;
  logic [PW-1:0]                      pay_q;
  logic [RMW-1:0]                     dsh;
  logic [RMW-1:0]                     rn;
  logic                               ge;

  // compare against the aligned divisor, subtract, shift up
  always_comb begin
    dsh = RMW'(s_i) << (DW - 1);
    rn  = '0;
    ge  = 1'b0;
    for (int l = 0; l < rmq_pkg::LANES; l++) begin
      ge       = (rem_i[l] >= dsh);
      rn       = ge ? (rem_i[l] - dsh) : rem_i[l];
      rem_d[l] = rn << 1;
      q_d[l]   = {q_i[l][DW-2:0], ge};
    end
  end

  // hold valid under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  // advance the data
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q   <= s_i;
      rem_q <= rem_d;
      q_q   <= q_d;
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign s_o     = s_q;
  assign rem_o   = rem_q;
  assign q_o     = q_q;
  assign pay_o   = pay_q;

endmodule

// ===== sv/rotation_matrix_to_quaternion.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Throughput: one request per cycle unless a result waits untaken at the
// output; set by the square-root cell chain and the divider cell chain, one
// cell per bit, SW = ceil((TW + FRAC_BITS) / 2), default format Q2.14.
// Reset clears all valid bits at once; the block takes requests right away.
// ----------------------------------------------------------------------------
// Branch select and trace term, a chain of square-root cells, a scaling
// stage, a chain of four-lane divider cells, then saturation.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion #(
  parameter int unsigned DATA_WIDTH = rmq_pkg::DATA_WIDTH,
  parameter int unsigned FRAC_BITS  = rmq_pkg::FRAC_BITS
) (
  input  logic clk_i,
  input  logic rst_ni,
  rmq_in_if.sink    in_i,
  rmq_out_if.source out_o
);

  localparam int unsigned DW   = DATA_WIDTH;
  localparam int unsigned FB   = FRAC_BITS;
  localparam int unsigned TW   = ((DW + 1 > FB) ? DW + 1 : FB) + 1;
  localparam int unsigned SW   = (TW + FB + 1) / 2;
  localparam int unsigned NW   = 2 * SW;
  localparam int unsigned RMW  = SW + DW + 1;
  localparam int unsigned NUMW = TW + FB;
  localparam int unsigned CMPW = ((NUMW > SW + DW) ? NUMW : SW + DW) + 1;
  localparam int unsigned L    = rmq_pkg::LANES;
  localparam int unsigned PW1  = 1 + L + L * TW;
  localparam int unsigned PW2  = 1 + L + L;

  logic en;

  // ---------------- front: branch select ----------------
  logic signed [TW:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, one;
  logic signed [TW:0] t;
  logic signed [TW:0] cw, cx, cy, cz;
  logic [L-1:0][TW:0] comp;
  logic [L-1:0][TW-1:0] mag_d;
  logic [L-1:0]       sgn_d;

  always_comb begin
    e00 = (TW+1)'(in_i.row0_col0);
    e01 = (TW+1)'(in_i.row0_col1);
    e02 = (TW+1)'(in_i.row0_col2);
    e10 = (TW+1)'(in_i.row1_col0);
    e11 = (TW+1)'(in_i.row1_col1);
    e12 = (TW+1)'(in_i.row1_col2);
    e20 = (TW+1)'(in_i.row2_col0);
    e21 = (TW+1)'(in_i.row2_col1);
    e22 = (TW+1)'(in_i.row2_col2);
    one = (TW+1)'(1) <<< FB;
    if (e22 < 0) begin
      if (e00 > e11) begin
        t  = one + e00 - e11 - e22;
        cx = t;         cy = e01 + e10; cz = e02 + e20; cw = e21 - e12;
      end else begin
        t  = one - e00 + e11 - e22;
        cx = e01 + e10; cy = t;         cz = e12 + e21; cw = e02 - e20;
      end
    end else begin
      if (e00 < -e11) begin
        t  = one - e00 - e11 + e22;
        cx = e02 + e20; cy = e12 + e21; cz = t;         cw = e10 - e01;
      end else begin
        t  = one + e00 + e11 + e22;
        cx = e21 - e12; cy = e02 - e20; cz = e10 - e01; cw = t;
      end
    end
    comp[rmq_pkg::LANE_W] = cw;
    comp[rmq_pkg::LANE_X] = cx;
    comp[rmq_pkg::LANE_Y] = cy;
    comp[rmq_pkg::LANE_Z] = cz;
    for (int l = 0; l < L; l++) begin
      sgn_d[l] = comp[l][TW];
      mag_d[l] = comp[l][TW] ? TW'(-comp[l]) : comp[l][TW-1:0];
    end
  end

  // register front stage
  logic               f_valid_q;
  logic               f_bad_q;
  logic [NW-1:0]      f_n_q;
  logic [L-1:0]       f_sgn_q;
  logic [L-1:0][TW-1:0] f_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_valid_q <= 1'b0;
    end else if (en) begin
      f_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_bad_q <= (t < 1);
      f_n_q   <= NW'(t[TW-1:0]) << FB;
      f_sgn_q <= sgn_d;
      f_mag_q <= mag_d;
    end
  end

  // ---------------- square-root cell chain ----------------
  logic [SW:0]            sq_valid;
  logic [SW:0][NW-1:0]    sq_n;
  logic [SW:0][SW+1:0]    sq_rem;
  logic [SW:0][SW-1:0]    sq_root;
  logic [SW:0][PW1-1:0]   sq_pay;

  assign sq_valid[0] = f_valid_q;
  assign sq_n[0]     = f_n_q;
  assign sq_rem[0]   = '0;
  assign sq_root[0]  = '0;
  assign sq_pay[0]   = {f_bad_q, f_sgn_q, f_mag_q};

  for (genvar i = 0; i < SW; i++) begin : g_sqrt
    rmq_sqrt_cell #(.SW(SW), .PW(PW1)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_valid[i]),
      .n_i     (sq_n[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .pay_i   (sq_pay[i]),
      .valid_o (sq_valid[i+1]),
      .n_o     (sq_n[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .pay_o   (sq_pay[i+1])
    );
  end

  // ---------------- scaling stage ----------------
  logic [SW-1:0]          s_w;
  logic                   s_bad;
  logic [L-1:0]           s_sgn;
  logic [L-1:0][TW-1:0]   s_mag;
  logic [CMPW-1:0]        num, lim;
  logic [L-1:0]           ov_d;
  logic [L-1:0][RMW-1:0]  rem_d;

  always_comb begin
    s_w                   = sq_root[SW];
    {s_bad, s_sgn, s_mag} = sq_pay[SW];
    lim                   = CMPW'(s_w) << DW;
    num                   = '0;
    for (int l = 0; l < L; l++) begin
      num      = (CMPW'(s_mag[l]) << (FB - 1)) + CMPW'(s_w >> 1);
      ov_d[l]  = (num >= lim);
      rem_d[l] = ov_d[l] ? '0 : num[RMW-1:0];
    end
  end

  logic                  p_valid_q;
  logic [SW-1:0]         p_s_q;
  logic [L-1:0][RMW-1:0] p_rem_q;
  logic [PW2-1:0]        p_pay_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else if (en) begin
      p_valid_q <= sq_valid[SW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_s_q   <= s_w;
      p_rem_q <= rem_d;
      p_pay_q <= {s_bad, ov_d, s_sgn};
    end
  end

  // ---------------- divider cell chain ----------------
  logic [DW:0]                  dv_valid;
  logic [DW:0][SW-1:0]          dv_s;
  logic [DW:0][L-1:0][RMW-1:0]  dv_rem;
  logic [DW:0][L-1:0][DW-1:0]   dv_q;
  logic [DW:0][PW2-1:0]         dv_pay;

  assign dv_valid[0] = p_valid_q;
  assign dv_s[0]     = p_s_q;
  assign dv_rem[0]   = p_rem_q;
  assign dv_q[0]     = '0;
  assign dv_pay[0]   = p_pay_q;

  for (genvar i = 0; i < DW; i++) begin : g_div
    rmq_div_cell #(.SW(SW), .DW(DW), .RMW(RMW), .PW(PW2)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_valid[i]),
      .s_i     (dv_s[i]),
      .rem_i   (dv_rem[i]),
      .q_i     (dv_q[i]),
      .pay_i   (dv_pay[i]),
      .valid_o (dv_valid[i+1]),
      .s_o     (dv_s[i+1]),
      .rem_o   (dv_rem[i+1]),
      .q_o     (dv_q[i+1]),
      .pay_o   (dv_pay[i+1])
    );
  end

  // ---------------- saturation and output register ----------------
  localparam logic [DW:0] MINM = (DW+1)'(1) << (DW - 1);
  localparam logic [DW:0] MAXV = MINM - (DW+1)'(1);

  logic                       o_bad;
  logic [L-1:0]               o_ov, o_sgn;
  logic [L-1:0][DW-1:0]       res_d;
  logic [DW:0]                qm;
  logic [DW-1:0]              one_sat;

  always_comb begin
    {o_bad, o_ov, o_sgn} = dv_pay[DW];
    one_sat = (FB >= DW - 1) ? MAXV[DW-1:0] : (DW'(1) << FB);
    qm      = '0;
    for (int l = 0; l < L; l++) begin
      qm = {1'b0, dv_q[DW][l]};
      if (o_sgn[l]) begin
        res_d[l] = (o_ov[l] || qm > MINM) ? MINM[DW-1:0] : DW'(-qm);
      end else begin
        res_d[l] = (o_ov[l] || qm > MAXV) ? MAXV[DW-1:0] : qm[DW-1:0];
      end
    end
    if (o_bad) begin
      res_d[rmq_pkg::LANE_W] = one_sat;
      res_d[rmq_pkg::LANE_X] = '0;
      res_d[rmq_pkg::LANE_Y] = '0;
      res_d[rmq_pkg::LANE_Z] = '0;
    end
  end

  logic                 o_valid_q;
  logic [L-1:0][DW-1:0] o_res_q;
  logic                 o_bad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_valid_q <= 1'b0;
    end else if (en) begin
      o_valid_q <= dv_valid[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      o_res_q <= res_d;
      o_bad_q <= o_bad;
    end
  end

  // advance the whole chain unless a result waits untaken
  assign en         = !o_valid_q || out_o.ready;
  assign in_i.ready = en;

  assign out_o.valid      = o_valid_q;
  assign out_o.quat_w     = o_res_q[rmq_pkg::LANE_W];
  assign out_o.quat_x     = o_res_q[rmq_pkg::LANE_X];
  assign out_o.quat_y     = o_res_q[rmq_pkg::LANE_Y];
  assign out_o.quat_z     = o_res_q[rmq_pkg::LANE_Z];
  assign out_o.bad_matrix = o_bad_q;

endmodule

// ===== test/rotation_matrix_to_quaternion_tb.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Drives matrix requests with random gaps, predicts each quaternion in the
// bench and compares results field by field in arrival order.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DATA_WIDTH  = rmq_pkg::DATA_WIDTH;
  localparam int FRAC_BITS   = rmq_pkg::FRAC_BITS;
  localparam int N_RANDOM    = 550;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 80;
  localparam int N_DIRECTED  = 16;

  typedef logic signed [DATA_WIDTH-1:0] entry_t;
  typedef struct packed {
    entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } matrix_t;
  typedef struct packed {
    entry_t w, x, y, z;
    logic   bad;
  } quat_t;
  typedef struct {
    matrix_t m;
    logic    known;
    quat_t   q;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   cycles = 0;
  int   errors = 0;
  bit   send_done = 1'b0;
  bit   hold_long = 1'b0;

  rmq_in_if  #(.DATA_WIDTH(DATA_WIDTH)) in_ch ();
  rmq_out_if #(.DATA_WIDTH(DATA_WIDTH)) out_ch ();

  rotation_matrix_to_quaternion uut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch),
    .out_o (out_ch)
  );

  quat_t expected_quats[$];
  row_t  directed[N_DIRECTED];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycles <= cycles + 1;

  // Integer square root of a nonnegative value
  function automatic longint unsigned isqrt(longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Scale one component by 0.5/sqrt(t), round half away, then clamp
  function automatic entry_t scale_sat(longint q, longint unsigned s);
    longint unsigned mag;
    longint r;
    longint maxv;
    mag = (q < 0) ? longint'(-q) : longint'(q);
    r = longint'(((mag << (FRAC_BITS - 1)) + (s >> 1)) / s);
    if (q < 0) r = -r;
    maxv = (longint'(1) << (DATA_WIDTH - 1)) - 1;
    if (r > maxv) r = maxv;
    if (r < -maxv - 1) r = -maxv - 1;
    return entry_t'(r);
  endfunction

  function automatic quat_t quat_of(matrix_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, one, t, qx, qy, qz, qw;
    longint unsigned s;
    quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one = longint'(1) << FRAC_BITS;
    // Pick the branch from the signs and order of the diagonal terms
    if (a22 < 0) begin
      if (a00 > a11) begin
        t = one + a00 - a11 - a22;
        qx = t; qy = a01 + a10; qz = a02 + a20; qw = a21 - a12;
      end else begin
        t = one - a00 + a11 - a22;
        qx = a01 + a10; qy = t; qz = a12 + a21; qw = a02 - a20;
      end
    end else if (a00 < -a11) begin
      t = one - a00 - a11 + a22;
      qx = a02 + a20; qy = a12 + a21; qz = t; qw = a10 - a01;
    end else begin
      t = one + a00 + a11 + a22;
      qx = a21 - a12; qy = a02 - a20; qz = a10 - a01; qw = t;
    end
    // Nonpositive trace term gives the identity with the error flag
    if (t < 1) begin
      q.w = (one > (longint'(1) << (DATA_WIDTH - 1)) - 1) ? '1 >> 1 : entry_t'(one);
      q.x = '0; q.y = '0; q.z = '0; q.bad = 1'b1;
      return q;
    end
    s = isqrt(longint'(t) << FRAC_BITS);
    q.w = scale_sat(qw, s);
    q.x = scale_sat(qx, s);
    q.y = scale_sat(qy, s);
    q.z = scale_sat(qz, s);
    q.bad = 1'b0;
    return q;
  endfunction

  function automatic matrix_t diag(int d0, int d1, int d2);
    matrix_t m;
    m = '0;
    m.m00 = entry_t'(d0); m.m11 = entry_t'(d1); m.m22 = entry_t'(d2);
    return m;
  endfunction

  function automatic entry_t rnd_entry(int mode);
    case (mode)
      0:       return entry_t'($urandom);
      1:       return entry_t'($urandom_range(0, 32768) - 16384);
      default: return entry_t'($urandom_range(0, 2000) - 1000);
    endcase
  endfunction

  // Mostly plausible rotation-like entries, some full-range noise
  function automatic matrix_t rnd_matrix();
    matrix_t m;
    int mode;
    mode = ($urandom_range(0, 3) == 0) ? 0 : 1;
    m.m00 = rnd_entry(mode); m.m01 = rnd_entry(mode); m.m02 = rnd_entry(mode);
    m.m10 = rnd_entry(mode); m.m11 = rnd_entry(mode); m.m12 = rnd_entry(mode);
    m.m20 = rnd_entry(mode); m.m21 = rnd_entry(mode); m.m22 = rnd_entry(mode);
    if ($urandom_range(0, 9) == 0) begin
      m.m01 = rnd_entry(2); m.m10 = rnd_entry(2);
    end
    return m;
  endfunction

  // Fill the directed table: identity, zero matrix, each branch, extremes
  initial begin
    directed[0]  = '{diag(16384, 16384, 16384), 1'b0, '0};
    // the zero matrix has t = one, so w comes out as one half
    directed[1]  = '{diag(0, 0, 0), 1'b1, '{8192, 0, 0, 0, 1'b0}};
    directed[2]  = '{diag(16384, -16384, -16384), 1'b0, '0};
    directed[3]  = '{diag(-16384, 16384, -16384), 1'b0, '0};
    directed[4]  = '{diag(-16384, -16384, 16384), 1'b0, '0};
    directed[5]  = '{diag(-32768, -32768, -32768), 1'b0, '0};
    directed[6]  = '{diag(32767, 32767, 32767), 1'b0, '0};
    directed[7]  = '{diag(-16384, -16384, -32768), 1'b0, '0};
    directed[8]  = '{diag(-32768, 32767, 0), 1'b0, '0};
    directed[9]  = '{'{default: entry_t'(-32768)}, 1'b0, '0};
    directed[10] = '{'{default: entry_t'(32767)}, 1'b0, '0};
    directed[11] = '{'{default: entry_t'(-1)}, 1'b0, '0};
    directed[12] = '{diag(-16384, -16384, -1), 1'b0, '0};
    directed[13] = '{diag(-16385, 0, 0), 1'b0, '0};
    directed[14] = '{diag(5, 5, -1), 1'b0, '0};
    directed[15] = '{diag(-8192, -8192, 0), 1'b0, '0};
  end

  // Drop valid only across an idle gap, so back-to-back requests stay high
  task automatic send_matrix(matrix_t m, logic known, quat_t q);
    quat_t exp_q;
    int    gap;
    exp_q = quat_of(m);
    if (known && exp_q !== q) begin
      $error("table row disagrees with prediction for %h", m);
      errors++;
    end
    gap = $urandom_range(0, 15);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    {in_ch.row0_col0, in_ch.row0_col1, in_ch.row0_col2, in_ch.row1_col0,
     in_ch.row1_col1, in_ch.row1_col2, in_ch.row2_col0, in_ch.row2_col1,
     in_ch.row2_col2} <= m;
    expected_quats.push_back(exp_q);
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // Request source
  initial begin
    in_ch.valid <= 1'b0;
    in_ch.row0_col0 <= '0; in_ch.row0_col1 <= '0; in_ch.row0_col2 <= '0;
    in_ch.row1_col0 <= '0; in_ch.row1_col1 <= '0; in_ch.row1_col2 <= '0;
    in_ch.row2_col0 <= '0; in_ch.row2_col1 <= '0; in_ch.row2_col2 <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < N_DIRECTED; i++)
      send_matrix(directed[i].m, directed[i].known, directed[i].q);
    // Pause until the pipe drains
    in_ch.valid <= 1'b0;
    while (expected_quats.size() != 0) @(posedge clk_i);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == 100) hold_long <= 1'b1;
      if (i == 200) hold_long <= 1'b0;
      // back-to-back burst with no gaps
      if (i >= 300 && i < 360) begin
        in_ch.valid <= 1'b1;
        {in_ch.row0_col0, in_ch.row0_col1, in_ch.row0_col2, in_ch.row1_col0,
         in_ch.row1_col1, in_ch.row1_col2, in_ch.row2_col0, in_ch.row2_col1,
         in_ch.row2_col2} <= rnd_matrix();
        @(posedge clk_i);
        while (!in_ch.ready) @(posedge clk_i);
        expected_quats.push_back(quat_of({in_ch.row0_col0, in_ch.row0_col1,
          in_ch.row0_col2, in_ch.row1_col0, in_ch.row1_col1, in_ch.row1_col2,
          in_ch.row2_col0, in_ch.row2_col1, in_ch.row2_col2}));
      end else begin
        send_matrix(rnd_matrix(), 1'b0, '0);
      end
    end
    in_ch.valid <= 1'b0;
    send_done <= 1'b1;
  end

  // Result sink with random and long stalls
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = hold_long ? 400 : $urandom_range(0, 15);
      if ($urandom_range(0, 3) == 0) stall = 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!out_ch.valid);
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin
    quat_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_quats.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_quats.pop_front();
        if (out_ch.quat_w !== e.w) begin
          $error("quat_w expected %0d got %0d", e.w, out_ch.quat_w); errors++;
        end
        if (out_ch.quat_x !== e.x) begin
          $error("quat_x expected %0d got %0d", e.x, out_ch.quat_x); errors++;
        end
        if (out_ch.quat_y !== e.y) begin
          $error("quat_y expected %0d got %0d", e.y, out_ch.quat_y); errors++;
        end
        if (out_ch.quat_z !== e.z) begin
          $error("quat_z expected %0d got %0d", e.z, out_ch.quat_z); errors++;
        end
        if (out_ch.bad_matrix !== e.bad) begin
          $error("bad_matrix expected %0d got %0d", e.bad, out_ch.bad_matrix);
          errors++;
        end
      end
    end
  end

  // End of run and timeout
  initial begin
    wait (send_done);
    while (expected_quats.size() != 0 && cycles < CYCLE_LIMIT) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (cycles >= CYCLE_LIMIT) errors++;
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT + 1000);
    $display("DONE: errors detected");
    $finish;
  end
endmodule
